[rtl/tricorn_escape_time_unit_defines.svh]
// Assertion macros shared by the escape-time RTL.
// No dependencies; clocked on clk, disabled while rst is high.
`ifndef TRICORN_ESCAPE_TIME_UNIT_DEFINES_SVH
`define TRICORN_ESCAPE_TIME_UNIT_DEFINES_SVH

// same-cycle implication
`define TET_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TET_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/tet_pkg.sv]
// Shared constants, codes and types of the escape-time unit.
// No dependencies; used by every module of the block.
package tet_pkg;

  localparam int FRAC_BITS        = 28;
  localparam int COLOR_SCALE      = 255;
  localparam int MAX_DIM          = 4096;
  localparam int MAX_ITER         = 1024;
  localparam int ESCAPE_BOUND     = 2;
  localparam int ESCAPE_RADIUS_SQ = 2 * 2;

  localparam int COORD_W   = 32;
  localparam int PIX_W     = 12;
  localparam int DIM_W     = 13;
  localparam int ITER_W    = 11;
  localparam int HUE_OFS_W = 9;
  localparam int HUE_W     = 10;
  localparam int CFG_IDX_W = 3;

  // divider: dividend is |edge difference| * pixel index
  localparam int DIV_W = COORD_W + PIX_W;
  localparam int DEN_W = DIM_W;
  // orbit values reach about +/-2^32 between escape tests
  localparam int ORB_W = COORD_W + 2;
  // hue quotient never exceeds COLOR_SCALE
  localparam int HQ_W  = $clog2(COLOR_SCALE + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_LOW   = 3'd0,
    REG_X_HIGH  = 3'd1,
    REG_Y_LOW   = 3'd2,
    REG_Y_HIGH  = 3'd3,
    REG_WIDTH   = 3'd4,
    REG_HEIGHT  = 3'd5,
    REG_LIMIT   = 3'd6,
    REG_HUE_OFS = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    TAG_X   = 2'd0,
    TAG_Y   = 2'd1,
    TAG_HUE = 2'd2
  } div_tag_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAP_X,
    S_MAP_Y,
    S_MAP_WAIT,
    S_ORBIT_GO,
    S_ORBIT,
    S_HUE,
    S_HUE_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             valid;
    div_tag_t         tag;
    logic [DEN_W-1:0] divisor;
    logic [DIV_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic             valid;
    div_tag_t         tag;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // one slot of the divider chain; work holds dividend bits (top) and
  // quotient bits (bottom)
  typedef struct packed {
    logic             valid;
    div_tag_t         tag;
    logic [DEN_W-1:0] divisor;
    logic [DEN_W-1:0] rem;
    logic [DIV_W-1:0] work;
  } div_stage_t;

  typedef struct packed {
    logic              done;
    logic [ITER_W-1:0] count;
  } orbit_sts_t;

endpackage

[rtl/tet_div_cell.sv]
// One restoring-division step with its output register.
// Depends on tet_pkg.
module tet_div_cell (
  input  logic               clk,
  input  logic               rst,
  input  tet_pkg::div_stage_t stage_in,
  output tet_pkg::div_stage_t stage_out
);
  import tet_pkg::*;

  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] trial;
  logic             fits;
  logic [DEN_W-1:0] rem_next;
  logic [DIV_W-1:0] work_next;

  always_comb begin
    shifted   = {stage_in.rem, stage_in.work[DIV_W-1]};
    trial     = {1'b0, shifted} - {2'b00, stage_in.divisor};
    fits      = ~trial[DEN_W+1];
    rem_next  = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
    work_next = {stage_in.work[DIV_W-2:0], fits};
  end

  // only the valid bit is reset; the data fields just follow
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else begin
      stage_out.valid <= stage_in.valid;
    end
    stage_out.tag     <= stage_in.tag;
    stage_out.divisor <= stage_in.divisor;
    stage_out.rem     <= rem_next;
    stage_out.work    <= work_next;
  end

endmodule

[rtl/tet_divider.sv]
// Pipelined divider: a chain of DIV_W division cells, one quotient bit each.
// Depends on tet_pkg and tet_div_cell.
module tet_divider (
  input  logic             clk,
  input  logic             rst,
  input  tet_pkg::div_req_t req,
  output tet_pkg::div_rsp_t rsp
);
  import tet_pkg::*;

  div_stage_t stage [DIV_W+1];

  assign stage[0] = {req.valid, req.tag, req.divisor, {DEN_W{1'b0}}, req.dividend};

  for (genvar i = 0; i < DIV_W; i++) begin : g_cell
    tet_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .stage_in  (stage[i]),
      .stage_out (stage[i+1])
    );
  end

  assign rsp = {stage[DIV_W].valid, stage[DIV_W].tag, stage[DIV_W].work};

endmodule

[rtl/tet_orbit.sv]
// Orbit engine: one conjugate-square iteration per cycle with escape test.
// Depends on tet_pkg.
module tet_orbit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [tet_pkg::COORD_W-1:0]  x0,
  input  logic signed [tet_pkg::COORD_W-1:0]  y0,
  input  logic        [tet_pkg::ITER_W-1:0]   limit,
  output tet_pkg::orbit_sts_t                 sts
);
  import tet_pkg::*;

  // operands are bounded by 2.0 whenever the products are used
  localparam int MAG_W = FRAC_BITS + 2;
  localparam int SQ_W  = 2 * MAG_W - FRAC_BITS;
  localparam int T_W   = 2 * MAG_W + 1 - FRAC_BITS;
  localparam int EXT_W = ORB_W - COORD_W;
  localparam logic [ORB_W-1:0] TWO  = ORB_W'(ESCAPE_BOUND) << FRAC_BITS;
  localparam logic [SQ_W:0]    FOUR = (SQ_W + 1)'(ESCAPE_RADIUS_SQ) << FRAC_BITS;

  logic                    busy;
  logic [ITER_W-1:0]       n;
  logic signed [ORB_W-1:0] x, y, x_next, y_next;
  logic [ORB_W-1:0]        mag_x, mag_y;
  logic [MAG_W-1:0]        mx, my;
  logic [MAG_W:0]          mx2;
  logic [2*MAG_W-1:0]      pxx, pyy;
  logic [2*MAG_W:0]        pxy;
  logic [SQ_W-1:0]         xx, yy;
  logic [T_W-1:0]          t_mag;
  logic [SQ_W:0]           rad;
  logic signed [ORB_W-1:0] xx_s, yy_s, t_s, x0_s, y0_s;
  logic                    stop;

  always_comb begin
    mag_x = x[ORB_W-1] ? ORB_W'(-x) : ORB_W'(x);
    mag_y = y[ORB_W-1] ? ORB_W'(-y) : ORB_W'(y);
    mx    = mag_x[MAG_W-1:0];
    my    = mag_y[MAG_W-1:0];
    mx2   = {mx, 1'b0};
    pxx   = mx * mx;
    pyy   = my * my;
    pxy   = mx2 * my;
    xx    = pxx[2*MAG_W-1:FRAC_BITS];
    yy    = pyy[2*MAG_W-1:FRAC_BITS];
    t_mag = pxy[2*MAG_W:FRAC_BITS];
    rad   = {1'b0, xx} + {1'b0, yy};
    xx_s  = signed'(ORB_W'(xx));
    yy_s  = signed'(ORB_W'(yy));
    // sign of (x+x)*y applied after truncation of the magnitude
    t_s   = (x[ORB_W-1] ^ y[ORB_W-1]) ? -signed'(ORB_W'(t_mag)) : signed'(ORB_W'(t_mag));
    x0_s  = {{EXT_W{x0[COORD_W-1]}}, x0};
    y0_s  = {{EXT_W{y0[COORD_W-1]}}, y0};
    x_next = xx_s - yy_s + x0_s;
    y_next = -(t_s + y0_s);
    stop  = (n >= limit) || (mag_x > TWO) || (mag_y > TWO) || (rad > FOUR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && stop) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= '0;
      y <= '0;
      n <= '0;
    end else if (busy && !stop) begin
      x <= x_next;
      y <= y_next;
      n <= n + 1'b1;
    end
  end

  assign sts.done  = busy & stop;
  assign sts.count = n;

endmodule

[rtl/tricorn_escape_time_unit.sv]
// Tricorn escape-time unit: each pixel takes two issues into the 44-cell divider
// chain, then one orbit iteration per cycle until escape or the limit, then one
// more pass through the chain for the hue, before out_valid rises.
// One pixel in flight: the next transaction is taken only after the last has
// reached the output register; a stalled output holds it off. Synchronous reset
// restores the register defaults and clears the FSM, divider valids and out_valid.
`include "tricorn_escape_time_unit_defines.svh"

module tricorn_escape_time_unit (
  input  logic                               clk,
  input  logic                               rst,
  // configuration writes
  input  logic                               cfg_wr_en,
  input  logic [tet_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tet_pkg::COORD_W-1:0]        cfg_wdata,
  // pixel input
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [tet_pkg::PIX_W-1:0]          pixel_col,
  input  logic [tet_pkg::PIX_W-1:0]          pixel_row,
  // result output
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tet_pkg::ITER_W-1:0]         escape_count,
  output logic [tet_pkg::HUE_W-1:0]          hue_value
);
  import tet_pkg::*;

  localparam int SUM_W = DIV_W + 2;
  localparam int SXT_W = SUM_W - COORD_W;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [COORD_W-1:0]   plane_x_low, plane_x_high, plane_y_low, plane_y_high;
  logic [DIM_W-1:0]     image_width, image_height;
  logic [ITER_W-1:0]    iteration_limit;
  logic [HUE_OFS_W-1:0] hue_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_x_low     <= 32'hE000_0000;   // -2.0
      plane_x_high    <= 32'h2000_0000;   // +2.0
      plane_y_low     <= 32'hE000_0000;
      plane_y_high    <= 32'h2000_0000;
      image_width     <= DIM_W'(1024);
      image_height    <= DIM_W'(1024);
      iteration_limit <= ITER_W'(256);
      hue_offset      <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_X_LOW:   plane_x_low     <= cfg_wdata;
        REG_X_HIGH:  plane_x_high    <= cfg_wdata;
        REG_Y_LOW:   plane_y_low     <= cfg_wdata;
        REG_Y_HIGH:  plane_y_high    <= cfg_wdata;
        REG_WIDTH:   image_width     <= cfg_wdata[DIM_W-1:0];
        REG_HEIGHT:  image_height    <= cfg_wdata[DIM_W-1:0];
        REG_LIMIT:   iteration_limit <= cfg_wdata[ITER_W-1:0];
        REG_HUE_OFS: hue_offset      <= cfg_wdata[HUE_OFS_W-1:0];
      endcase
    end
  end

  // Divisors clamp to 1..MAX_DIM, the limit to MAX_ITER.
  logic [DEN_W-1:0]  width_eff, height_eff, lim_div;
  logic [ITER_W-1:0] lim_eff;

  always_comb begin
    width_eff  = (image_width == '0) ? DEN_W'(1) :
                 (image_width > DEN_W'(MAX_DIM)) ? DEN_W'(MAX_DIM) : image_width;
    height_eff = (image_height == '0) ? DEN_W'(1) :
                 (image_height > DEN_W'(MAX_DIM)) ? DEN_W'(MAX_DIM) : image_height;
    lim_eff    = (iteration_limit > ITER_W'(MAX_ITER)) ? ITER_W'(MAX_ITER)
                                                       : iteration_limit;
    // zero limit means zero count, so 0/1 gives the wanted zero quotient
    lim_div    = (lim_eff == '0) ? DEN_W'(1) : DEN_W'(lim_eff);
  end

  // ---------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------
  state_t state, state_next;

  logic [PIX_W-1:0]   col_q, row_q;
  logic               neg_x, neg_y;
  logic [COORD_W-1:0] x0_q, y0_q;
  logic [ITER_W-1:0]  count_q;
  logic [HUE_W-1:0]   hue_q;
  logic               load;

  div_req_t   div_req;
  div_rsp_t   div_rsp;
  orbit_sts_t orb_sts;

  // ---------------------------------------------------------------------
  // Window mapping: |hi - lo| * index goes into the divider, sign kept aside
  // ---------------------------------------------------------------------
  logic               sel_y;
  logic [COORD_W-1:0] map_lo, map_hi;
  logic [PIX_W-1:0]   map_idx;
  logic [DEN_W-1:0]   map_den;
  logic [COORD_W:0]   diff, diff_mag;
  logic [DIV_W-1:0]   prod;
  logic [DIV_W-1:0]   hue_num;

  always_comb begin
    sel_y    = (state == S_MAP_Y);
    map_lo   = sel_y ? plane_y_low  : plane_x_low;
    map_hi   = sel_y ? plane_y_high : plane_x_high;
    map_idx  = sel_y ? row_q        : col_q;
    map_den  = sel_y ? height_eff   : width_eff;
    diff     = {map_hi[COORD_W-1], map_hi} - {map_lo[COORD_W-1], map_lo};
    diff_mag = diff[COORD_W] ? (~diff + 1'b1) : diff;
    prod     = DIV_W'(diff_mag[COORD_W-1:0]) * DIV_W'(map_idx);
    hue_num  = DIV_W'(count_q) * DIV_W'(COLOR_SCALE);
  end

  always_comb begin
    div_req.valid    = (state == S_MAP_X) || (state == S_MAP_Y) || (state == S_HUE);
    div_req.tag      = (state == S_HUE) ? TAG_HUE : (sel_y ? TAG_Y : TAG_X);
    div_req.dividend = (state == S_HUE) ? hue_num : prod;
    div_req.divisor  = (state == S_HUE) ? lim_div : map_den;
  end

  tet_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Quotient back: restore sign, add low edge, saturate to 32 bits.
  logic               post_y, post_neg, post_ovf;
  logic [COORD_W-1:0] post_lo, coord_sat;
  logic [SUM_W-1:0]   q_ext, q_signed, coord_sum;

  always_comb begin
    post_y    = (div_rsp.tag == TAG_Y);
    post_lo   = post_y ? plane_y_low : plane_x_low;
    post_neg  = post_y ? neg_y : neg_x;
    q_ext     = {2'b00, div_rsp.quotient};
    q_signed  = post_neg ? (~q_ext + 1'b1) : q_ext;
    coord_sum = q_signed + {{SXT_W{post_lo[COORD_W-1]}}, post_lo};
    post_ovf  = !((&coord_sum[SUM_W-1:COORD_W-1]) || ~(|coord_sum[SUM_W-1:COORD_W-1]));
    if (post_ovf) begin
      coord_sat = coord_sum[SUM_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                     : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      coord_sat = coord_sum[COORD_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Orbit
  // ---------------------------------------------------------------------
  tet_orbit u_orbit (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_ORBIT_GO),
    .x0    (signed'(x0_q)),
    .y0    (signed'(y0_q)),
    .limit (lim_eff),
    .sts   (orb_sts)
  );

  // ---------------------------------------------------------------------
  // FSM
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load       = 1'b0;
    unique case (state)
      S_IDLE:     if (in_valid) state_next = S_MAP_X;
      S_MAP_X:    state_next = S_MAP_Y;
      S_MAP_Y:    state_next = S_MAP_WAIT;
      S_MAP_WAIT: if (div_rsp.valid && div_rsp.tag == TAG_Y) state_next = S_ORBIT_GO;
      S_ORBIT_GO: state_next = S_ORBIT;
      S_ORBIT:    if (orb_sts.done) state_next = S_HUE;
      S_HUE:      state_next = S_HUE_WAIT;
      S_HUE_WAIT: if (div_rsp.valid && div_rsp.tag == TAG_HUE) state_next = S_DONE;
      S_DONE: begin
        if (!out_valid || out_ready) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      col_q <= pixel_col;
      row_q <= pixel_row;
    end
    if (state == S_MAP_X) neg_x <= diff[COORD_W];
    if (state == S_MAP_Y) neg_y <= diff[COORD_W];
    if (div_rsp.valid && div_rsp.tag == TAG_X) x0_q <= coord_sat;
    if (div_rsp.valid && div_rsp.tag == TAG_Y) y0_q <= coord_sat;
    if (state == S_ORBIT && orb_sts.done) count_q <= orb_sts.count;
    if (div_rsp.valid && div_rsp.tag == TAG_HUE) begin
      hue_q <= HUE_W'(div_rsp.quotient[HQ_W-1:0]) + HUE_W'(hue_offset);
    end
    if (load) begin
      escape_count <= count_q;
      hue_value    <= hue_q;
    end
  end

  // output register handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `TET_ASSERT_NEXT(a_accept_starts_map, in_valid && in_ready, state == S_MAP_X,
                   "accepted pixel did not start mapping")
  `TET_ASSERT_IMPL(a_rsp_only_waiting, div_rsp.valid,
                   state == S_MAP_WAIT || state == S_HUE_WAIT,
                   "divider result outside a wait state")
  `TET_ASSERT_IMPL(a_done_in_orbit, orb_sts.done, state == S_ORBIT,
                   "orbit finished outside orbit state")
  `TET_ASSERT_IMPL(a_count_in_limit, orb_sts.done, orb_sts.count <= lim_eff,
                   "escape count beyond limit")
  `TET_ASSERT_IMPL(a_valid_from_done, $rose(out_valid), $past(state) == S_DONE,
                   "result shown without finishing")

endmodule
